// ===== src/lsep_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsep_pkg
// Shared types, codes and tables for the log-sum-exp posterior block.
// ---------------------------------------------------------------------------
package lsep_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_CLASSES_DEF = 8;
  localparam int VALUE_BITS_DEF  = 24;

  // Fixed field widths
  localparam int CLASS_BITS = 3;
  localparam int COUNT_BITS = 4;
  localparam int FRAC_BITS  = 16;
  localparam int RESULT_CAP = 8;

  localparam logic [COUNT_BITS-1:0] CLASS_COUNT_RST = 4'd2;

  // Correction term fixed point layout
  localparam int CORR_BITS = 16;
  localparam int CORR_FRAC = 15;
  localparam int CORR_LIMIT_BIT = 19;   // 8.0 in Q16

  // Input actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_ELEM = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_JOIN,
    ST_CORR,
    ST_UPD,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_OUT
  } lsep_state_t;

  // log(1+exp(-i/2)) in Q16 for i = 0..16
  function automatic logic [CORR_BITS-1:0] corr_lut(input logic [4:0] idx);
    logic [CORR_BITS-1:0] v;
    case (idx)
      5'd0:    v = 16'd45426;
      5'd1:    v = 16'd31069;
      5'd2:    v = 16'd20530;
      5'd3:    v = 16'd13200;
      5'd4:    v = 16'd8318;
      5'd5:    v = 16'd5170;
      5'd6:    v = 16'd3184;
      5'd7:    v = 16'd1950;
      5'd8:    v = 16'd1189;
      5'd9:    v = 16'd724;
      5'd10:   v = 16'd440;
      5'd11:   v = 16'd267;
      5'd12:   v = 16'd162;
      5'd13:   v = 16'd98;
      5'd14:   v = 16'd60;
      5'd15:   v = 16'd36;
      5'd16:   v = 16'd22;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/log_sum_exp_posterior_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// log_sum_exp_posterior_top
// Log-domain posterior normalisation over the classes of one observation.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): an item with in_action = load writes
//   the log prior of class in_class_index. An item with in_action = element
//   carries the log-likelihood of the next class of the current observation;
//   it passes through prior read, joint sum, table correction and log-sum-exp
//   update, except the first element of an observation, which stops after
//   prior read and joint sum. in_stall is high while an item is in work or
//   results are being emitted.
//   After the element that completes an observation (class_count classes),
//   one result item per class leaves on out_valid / out_stall, class 0 first,
//   with out_last on the final one. Each result passes through memory read,
//   output load and hand-over, the last held while the receiver holds
//   out_stall; a stalled result holds its payload. The next result is not
//   read until the current one has been handed over.
//   Configuration: cfg_class_count is written when cfg_valid is high;
//   cfg_ready is always high. Write only while the block is idle.
//   Reset (rst_n low, synchronous): class_count = 2, all priors read as zero,
//   running log-sum-exp at the most negative value, no elements held.
// ---------------------------------------------------------------------------
module log_sum_exp_posterior_top #(
  parameter int MAX_CLASSES = lsep_pkg::MAX_CLASSES_DEF,
  parameter int VALUE_BITS  = lsep_pkg::VALUE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_action,
  input  logic [lsep_pkg::CLASS_BITS-1:0]       in_class_index,
  input  logic signed [VALUE_BITS-1:0]          in_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [lsep_pkg::CLASS_BITS-1:0]       out_class,
  output logic signed [VALUE_BITS-1:0]          out_posterior,
  output logic signed [VALUE_BITS-1:0]          out_prior_value,
  output logic signed [VALUE_BITS-1:0]          out_obs_loglik,
  output logic                                  out_last,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lsep_pkg::COUNT_BITS-1:0]       cfg_class_count
);

  localparam int AW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int VB = VALUE_BITS;
  localparam int SW = VB + 2;
  localparam int DW = (SW > lsep_pkg::CORR_LIMIT_BIT + 1) ? SW : lsep_pkg::CORR_LIMIT_BIT + 1;
  localparam int CB = lsep_pkg::CORR_BITS;
  localparam int CF = lsep_pkg::CORR_FRAC;
  localparam int NB = lsep_pkg::COUNT_BITS;
  localparam int NMAX = (MAX_CLASSES < lsep_pkg::RESULT_CAP) ? MAX_CLASSES
                                                              : lsep_pkg::RESULT_CAP;
  localparam logic signed [SW-1:0] VMAX_W = SW'((64'sd1 <<< (VB - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] VMIN_W = -VMAX_W - SW'(1);
  localparam logic signed [VB-1:0] VMIN   = VMIN_W[VB-1:0];

  // Clamp a wide sum to the value range
  function automatic logic signed [VB-1:0] sat(input logic signed [SW-1:0] x);
    logic signed [VB-1:0] r;
    if (x > VMAX_W) begin
      r = VMAX_W[VB-1:0];
    end else if (x < VMIN_W) begin
      r = VMIN;
    end else begin
      r = x[VB-1:0];
    end
    return r;
  endfunction

  lsep_pkg::lsep_state_t state_r, state_nxt;

  logic [NB-1:0]        class_count_r;
  logic [NB-1:0]        cnt_r, cnt_nxt;
  logic [NB-1:0]        k_r, k_nxt;
  logic [AW-1:0]        slot_r, slot_nxt;
  logic signed [VB-1:0] val_r, val_nxt;
  logic signed [VB-1:0] lse_r, lse_nxt;
  logic signed [VB-1:0] hi_r, hi_nxt;
  logic [DW-1:0]        dist_r, dist_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [lsep_pkg::CLASS_BITS-1:0] out_class_r, out_class_nxt;
  logic signed [VB-1:0] out_post_r, out_post_nxt;
  logic signed [VB-1:0] out_prior_r, out_prior_nxt;
  logic signed [VB-1:0] out_lse_r, out_lse_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 prior_we;
  logic [AW-1:0]        prior_raddr;
  logic [VB-1:0]        prior_rdata;
  logic                 joint_we;
  logic signed [VB-1:0] joint_w;
  logic [VB-1:0]        joint_rdata;
  logic [CB-1:0]        corr_base;
  logic [CB+CF-1:0]     corr_prod;
  logic [NB-1:0]        eff_n;
  logic                 in_acc;
  logic                 load_ok;
  logic [AW-1:0]        slot_sel;
  logic signed [VB-1:0] hi_w, lo_w;
  logic signed [SW-1:0] corr_w;

  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign load_ok   = 32'(in_class_index) < MAX_CLASSES;
  assign prior_we  = in_acc && (in_action == lsep_pkg::ACT_LOAD) && load_ok;
  assign slot_sel  = (32'(cnt_r) >= MAX_CLASSES) ? AW'(MAX_CLASSES - 1) : AW'(cnt_r);

  // Effective class count, clamped to 1..min(MAX_CLASSES, 8)
  always_comb begin
    if (class_count_r == '0) begin
      eff_n = NB'(1);
    end else if (32'(class_count_r) > NMAX) begin
      eff_n = NB'(NMAX);
    end else begin
      eff_n = class_count_r;
    end
  end

  lsep_prior_store #(.MAX_CLASSES(MAX_CLASSES), .VALUE_BITS(VB)) u_prior (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (prior_we),
    .waddr   (AW'(in_class_index)),
    .wdata   (in_value),
    .raddr   (prior_raddr),
    .rdata_r (prior_rdata)
  );

  lsep_joint_store #(.MAX_CLASSES(MAX_CLASSES), .VALUE_BITS(VB)) u_joint (
    .clk     (clk),
    .we      (joint_we),
    .waddr   (slot_r),
    .wdata   (joint_w),
    .raddr   (AW'(k_r)),
    .rdata_r (joint_rdata)
  );

  lsep_corr #(.DW(DW)) u_corr (
    .clk    (clk),
    .delta  (dist_r),
    .base_r (corr_base),
    .prod_r (corr_prod)
  );

  // Joint sum, ordering against the running value, correction term
  always_comb begin
    joint_w = sat(SW'($signed(prior_rdata)) + SW'(val_r));
    hi_w    = (lse_r > joint_w) ? lse_r : joint_w;
    lo_w    = (lse_r > joint_w) ? joint_w : lse_r;
    corr_w  = SW'({1'b0, corr_base}) - SW'({1'b0, corr_prod[CB+CF-1:CF]});
  end

  // Sequencer: next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    slot_nxt      = slot_r;
    val_nxt       = val_r;
    lse_nxt       = lse_r;
    hi_nxt        = hi_r;
    dist_nxt      = dist_r;
    out_valid_nxt = out_valid_r;
    out_class_nxt = out_class_r;
    out_post_nxt  = out_post_r;
    out_prior_nxt = out_prior_r;
    out_lse_nxt   = out_lse_r;
    out_last_nxt  = out_last_r;
    in_stall      = 1'b1;
    joint_we      = 1'b0;
    prior_raddr   = AW'(k_r);
    case (state_r)
      lsep_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        prior_raddr = slot_sel;
        if (in_acc && (in_action == lsep_pkg::ACT_ELEM)) begin
          slot_nxt  = slot_sel;
          val_nxt   = in_value;
          state_nxt = lsep_pkg::ST_JOIN;
        end
      end
      lsep_pkg::ST_JOIN: begin
        joint_we = 1'b1;
        hi_nxt   = hi_w;
        dist_nxt = DW'(SW'(hi_w) - SW'(lo_w));
        if (cnt_r == '0) begin
          lse_nxt = joint_w;
          cnt_nxt = cnt_r + NB'(1);
          if (NB'(1) >= eff_n) begin
            k_nxt     = '0;
            state_nxt = lsep_pkg::ST_EMIT_RD;
          end else begin
            state_nxt = lsep_pkg::ST_IDLE;
          end
        end else begin
          state_nxt = lsep_pkg::ST_CORR;
        end
      end
      lsep_pkg::ST_CORR: begin
        state_nxt = lsep_pkg::ST_UPD;
      end
      lsep_pkg::ST_UPD: begin
        lse_nxt = sat(SW'(hi_r) + corr_w);
        cnt_nxt = cnt_r + NB'(1);
        if (cnt_r + NB'(1) >= eff_n) begin
          k_nxt     = '0;
          state_nxt = lsep_pkg::ST_EMIT_RD;
        end else begin
          state_nxt = lsep_pkg::ST_IDLE;
        end
      end
      lsep_pkg::ST_EMIT_RD: begin
        state_nxt = lsep_pkg::ST_EMIT_LD;
      end
      lsep_pkg::ST_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        out_class_nxt = k_r[lsep_pkg::CLASS_BITS-1:0];
        out_post_nxt  = sat(SW'($signed(joint_rdata)) - SW'(lse_r));
        out_prior_nxt = prior_rdata;
        out_lse_nxt   = lse_r;
        out_last_nxt  = (k_r + NB'(1) == eff_n);
        state_nxt     = lsep_pkg::ST_EMIT_OUT;
      end
      lsep_pkg::ST_EMIT_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            lse_nxt   = VMIN;
            cnt_nxt   = '0;
            state_nxt = lsep_pkg::ST_IDLE;
          end else begin
            k_nxt     = k_r + NB'(1);
            state_nxt = lsep_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = lsep_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= lsep_pkg::ST_IDLE;
      class_count_r <= lsep_pkg::CLASS_COUNT_RST;
      cnt_r         <= '0;
      k_r           <= '0;
      lse_r         <= VMIN;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      lse_r       <= lse_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        class_count_r <= cfg_class_count;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    slot_r      <= slot_nxt;
    val_r       <= val_nxt;
    hi_r        <= hi_nxt;
    dist_r      <= dist_nxt;
    out_class_r <= out_class_nxt;
    out_post_r  <= out_post_nxt;
    out_prior_r <= out_prior_nxt;
    out_lse_r   <= out_lse_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_class       = out_class_r;
  assign out_posterior   = out_post_r;
  assign out_prior_value = out_prior_r;
  assign out_obs_loglik  = out_lse_r;
  assign out_last        = out_last_r;

endmodule

// ===== src/lsep_prior_store.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsep_prior_store
// Log prior memory, one write and one registered read port; entries read
// as zero until first loaded.
// ---------------------------------------------------------------------------
module lsep_prior_store #(
  parameter int MAX_CLASSES = lsep_pkg::MAX_CLASSES_DEF,
  parameter int VALUE_BITS  = lsep_pkg::VALUE_BITS_DEF,
  localparam int AW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [VALUE_BITS-1:0] wdata,
  input  logic [AW-1:0]         raddr,
  output logic [VALUE_BITS-1:0] rdata_r
);

  logic [VALUE_BITS-1:0]  mem [MAX_CLASSES];
  logic [MAX_CLASSES-1:0] vld_r;

  // Write entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Track loaded entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  // Registered read, unloaded entries give zero
  always_ff @(posedge clk) begin
    rdata_r <= vld_r[raddr] ? mem[raddr] : '0;
  end

endmodule

// ===== src/lsep_joint_store.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsep_joint_store
// Buffer of joint sums (prior plus likelihood) for one observation.
// ---------------------------------------------------------------------------
module lsep_joint_store #(
  parameter int MAX_CLASSES = lsep_pkg::MAX_CLASSES_DEF,
  parameter int VALUE_BITS  = lsep_pkg::VALUE_BITS_DEF,
  localparam int AW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [VALUE_BITS-1:0] wdata,
  input  logic [AW-1:0]         raddr,
  output logic [VALUE_BITS-1:0] rdata_r
);

  logic [VALUE_BITS-1:0] mem [MAX_CLASSES];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== src/lsep_corr.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsep_corr
// Table lookup and interpolation product for log(1+exp(-d)), registered.
// ---------------------------------------------------------------------------
module lsep_corr #(
  parameter int DW = 20
) (
  input  logic                              clk,
  input  logic [DW-1:0]                     delta,
  output logic [lsep_pkg::CORR_BITS-1:0]    base_r,
  output logic [lsep_pkg::CORR_BITS+lsep_pkg::CORR_FRAC-1:0] prod_r
);

  localparam int CB = lsep_pkg::CORR_BITS;
  localparam int CF = lsep_pkg::CORR_FRAC;
  localparam int LB = lsep_pkg::CORR_LIMIT_BIT;

  logic          big;
  logic [4:0]    idx;
  logic [CF-1:0] frac;
  logic [CB-1:0] a;
  logic [CB-1:0] b;

  // Split distance into segment and fraction
  always_comb begin
    big  = |delta[DW-1:LB];
    idx  = {1'b0, delta[LB-1:CF]};
    frac = delta[CF-1:0];
    a    = lsep_pkg::corr_lut(idx);
    b    = lsep_pkg::corr_lut(idx + 5'd1);
  end

  // Register base and slope product; from 8.0 up the term is zero
  always_ff @(posedge clk) begin
    base_r <= big ? '0 : a;
    prod_r <= big ? '0 : (a - b) * frac;
  end

endmodule
